// ===== src/assert_macros.svh =====
// Assertion macros used by the RTL of the Euler XYZ rotation block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at each rising edge outside reset.
`define EXR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("exr assertion failed");
// Next-cycle implication.
`define EXR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("exr assertion failed");
`else
`define EXR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define EXR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/exr_pkg.sv =====
// Package of the Euler XYZ rotation block: default widths and register indexes.
`default_nettype none
package exr_pkg;

  localparam int COORD_BITS_DEF     = 16;
  localparam int COEF_FRAC_BITS_DEF = 14;
  localparam int CFG_IDX_BITS       = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_COS_X = 3'd0,
    REG_SIN_X = 3'd1,
    REG_COS_Y = 3'd2,
    REG_SIN_Y = 3'd3,
    REG_COS_Z = 3'd4,
    REG_SIN_Z = 3'd5
  } cfg_reg_t;

endpackage
`default_nettype wire

// ===== src/exr_ifs.sv =====
// Point and result channel interfaces of the Euler XYZ rotation block.
`default_nettype none
interface exr_in_if
  import exr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] x_in;
  logic signed [COORD_BITS-1:0] y_in;
  logic signed [COORD_BITS-1:0] z_in;
  logic                         last_in;

  modport source (output valid, x_in, y_in, z_in, last_in, input ready);
  modport sink   (input valid, x_in, y_in, z_in, last_in, output ready);
endinterface

interface exr_out_if
  import exr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                       valid;
  logic                       ready;
  logic signed [COORD_BITS:0] x_out;
  logic signed [COORD_BITS:0] y_out;
  logic signed [COORD_BITS:0] z_out;
  logic                       last_out;

  modport source (output valid, x_out, y_out, z_out, last_out, input ready);
  modport sink   (input valid, x_out, y_out, z_out, last_out, output ready);
endinterface
`default_nettype wire

// ===== src/euler_xyz_point_rotation_core.sv =====
// Euler XYZ point rotation core: X, then Y, then Z rotation of a point stream.
//
// Usage:
//   in_pt  : point requests (x_in, y_in, z_in, last_in), valid/ready.
//   out_pt : rotated points (x_out, y_out, z_out, last_out), valid/ready.
//   cfg_*  : write-only coefficient port; cos/sin per axis in signed fixed point
//            with COEF_FRAC_BITS fraction bits. Write only while the pipe is empty.
// Pipeline: seven register stages; a request is loaded into the first stage at the
//   edge that accepts it, and its result is taken from the seventh.
// Throughput: one point per cycle unless out_pt stalls; each axis takes a multiply
//   stage and an add/round stage, a seventh stage saturates and is the output register.
// Each axis result is rounded half up to an integer before the next axis;
//   the final values saturate to -2^COORD_BITS .. 2^COORD_BITS-1.
// Reset (rst_n low, synchronous): pipe emptied, cos = 1.0, sin = 0 (identity).
// Receiver stall: stages hold; bubbles inside the pipe still close up, so
//   in_pt.ready drops only when all seven stages are full.
// last_in travels with its point and comes out as last_out.
`default_nettype none
`include "assert_macros.svh"
module euler_xyz_point_rotation_core
  import exr_pkg::*;
#(
  parameter int COORD_BITS     = COORD_BITS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  exr_in_if.sink                             in_pt,
  exr_out_if.source                          out_pt,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  wire logic [COEF_FRAC_BITS+1:0]     cfg_data
);

  // widths: coefficient, and per-axis growth (product + sum + round - shift)
  localparam int W   = COORD_BITS;
  localparam int F   = COEF_FRAC_BITS;
  localparam int CB  = F + 2;
  localparam int W1  = W + 4;
  localparam int W2  = W1 + 4;
  localparam int W3  = W2 + 4;
  localparam int P0  = W + CB;
  localparam int P1  = W1 + CB;
  localparam int P2  = W2 + CB;
  localparam int SW0 = P0 + 2;
  localparam int SW1 = P1 + 2;
  localparam int SW2 = P2 + 2;
  localparam int NST = 7;

  localparam logic signed [CB-1:0]  COEF_ONE = CB'(1) << F;
  localparam logic signed [SW0-1:0] HALF0    = SW0'(1) << (F - 1);
  localparam logic signed [SW1-1:0] HALF1    = SW1'(1) << (F - 1);
  localparam logic signed [SW2-1:0] HALF2    = SW2'(1) << (F - 1);
  localparam logic signed [W3-1:0]  SAT_HI   = {{(W3-W){1'b0}}, {W{1'b1}}};
  localparam logic signed [W3-1:0]  SAT_LO   = {{(W3-W){1'b1}}, {W{1'b0}}};

  function automatic logic signed [W:0] sat_f(input logic signed [W3-1:0] v);
    logic signed [W3-1:0] c;
    begin
      priority if (v > SAT_HI) c = SAT_HI;
      else if (v < SAT_LO)     c = SAT_LO;
      else                     c = v;
      return c[W:0];
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Coefficient registers
  // ---------------------------------------------------------------------------
  logic signed [CB-1:0] cx_r, sx_r, cy_r, sy_r, cz_r, sz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= COEF_ONE;
      sx_r <= '0;
      cy_r <= COEF_ONE;
      sy_r <= '0;
      cz_r <= COEF_ONE;
      sz_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COS_X: cx_r <= cfg_data;
        REG_SIN_X: sx_r <= cfg_data;
        REG_COS_Y: cy_r <= cfg_data;
        REG_SIN_Y: sy_r <= cfg_data;
        REG_COS_Z: cz_r <= cfg_data;
        REG_SIN_Z: sz_r <= cfg_data;
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage control: a stage loads when empty or when the next one loads
  // ---------------------------------------------------------------------------
  logic [NST-1:0] v_r;
  logic [NST-1:0] en;
  logic           in_fire;

  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_pt.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_pt.ready = en[0];
  assign in_fire     = in_pt.valid && in_pt.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_pt.valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  // stage 1: X-axis products
  logic signed [P0-1:0]  s1_yc_r, s1_zs_r, s1_zc_r, s1_ys_r;
  logic signed [W-1:0]   s1_x_r;
  // stage 2: X-axis sums, rounded
  logic signed [SW0-1:0] s2_ysum, s2_zsum;
  logic signed [W1-1:0]  s2_y_r, s2_z_r;
  logic signed [W-1:0]   s2_x_r;
  // stage 3: Y-axis products
  logic signed [P1-1:0]  s3_xc_r, s3_zs_r, s3_zc_r, s3_xs_r;
  logic signed [W1-1:0]  s3_y_r;
  // stage 4: Y-axis sums, rounded
  logic signed [SW1-1:0] s4_xsum, s4_zsum;
  logic signed [W2-1:0]  s4_x_r, s4_z_r;
  logic signed [W1-1:0]  s4_y_r;
  // stage 5: Z-axis products
  logic signed [P2-1:0]  s5_xc_r, s5_ys_r, s5_xs_r, s5_yc_r;
  logic signed [W2-1:0]  s5_z_r;
  // stage 6: Z-axis sums, rounded
  logic signed [SW2-1:0] s6_xsum, s6_ysum;
  logic signed [W3-1:0]  s6_x_r, s6_y_r;
  logic signed [W2-1:0]  s6_z_r;
  // stage 7: saturated output register
  logic signed [W:0]     s7_x_r, s7_y_r, s7_z_r;
  logic [NST-1:0]        last_r;

  // adding one half then dropping the fraction rounds half up (floor shift)
  always_comb begin
    s2_ysum = SW0'(s1_yc_r) + SW0'(s1_zs_r) + HALF0;
    s2_zsum = SW0'(s1_zc_r) - SW0'(s1_ys_r) + HALF0;
    s4_xsum = SW1'(s3_xc_r) + SW1'(s3_zs_r) + HALF1;
    s4_zsum = SW1'(s3_zc_r) - SW1'(s3_xs_r) + HALF1;
    s6_xsum = SW2'(s5_xc_r) - SW2'(s5_ys_r) + HALF2;
    s6_ysum = SW2'(s5_xs_r) + SW2'(s5_yc_r) + HALF2;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_yc_r   <= P0'(in_pt.y_in) * P0'(cx_r);
      s1_zs_r   <= P0'(in_pt.z_in) * P0'(sx_r);
      s1_zc_r   <= P0'(in_pt.z_in) * P0'(cx_r);
      s1_ys_r   <= P0'(in_pt.y_in) * P0'(sx_r);
      s1_x_r    <= in_pt.x_in;
      last_r[0] <= in_pt.last_in;
    end
    if (en[1]) begin
      s2_y_r    <= s2_ysum[SW0-1:F];
      s2_z_r    <= s2_zsum[SW0-1:F];
      s2_x_r    <= s1_x_r;
      last_r[1] <= last_r[0];
    end
    if (en[2]) begin
      s3_xc_r   <= P1'(s2_x_r) * P1'(cy_r);
      s3_zs_r   <= P1'(s2_z_r) * P1'(sy_r);
      s3_zc_r   <= P1'(s2_z_r) * P1'(cy_r);
      s3_xs_r   <= P1'(s2_x_r) * P1'(sy_r);
      s3_y_r    <= s2_y_r;
      last_r[2] <= last_r[1];
    end
    if (en[3]) begin
      s4_x_r    <= s4_xsum[SW1-1:F];
      s4_z_r    <= s4_zsum[SW1-1:F];
      s4_y_r    <= s3_y_r;
      last_r[3] <= last_r[2];
    end
    if (en[4]) begin
      s5_xc_r   <= P2'(s4_x_r) * P2'(cz_r);
      s5_ys_r   <= P2'(s4_y_r) * P2'(sz_r);
      s5_xs_r   <= P2'(s4_x_r) * P2'(sz_r);
      s5_yc_r   <= P2'(s4_y_r) * P2'(cz_r);
      s5_z_r    <= s4_z_r;
      last_r[4] <= last_r[3];
    end
    if (en[5]) begin
      s6_x_r    <= s6_xsum[SW2-1:F];
      s6_y_r    <= s6_ysum[SW2-1:F];
      s6_z_r    <= s5_z_r;
      last_r[5] <= last_r[4];
    end
    if (en[6]) begin
      s7_x_r    <= sat_f(s6_x_r);
      s7_y_r    <= sat_f(s6_y_r);
      s7_z_r    <= sat_f(W3'(s6_z_r));
      last_r[6] <= last_r[5];
    end
  end

  assign out_pt.valid    = v_r[NST-1];
  assign out_pt.x_out    = s7_x_r;
  assign out_pt.y_out    = s7_y_r;
  assign out_pt.z_out    = s7_z_r;
  assign out_pt.last_out = last_r[NST-1];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // an accepted request always lands in the first stage
  `EXR_ASSERT_NXT(a_in_lands, clk, rst_n, in_fire, v_r[0])
  // backpressure only when every stage holds a point
  `EXR_ASSERT_IMP(a_full_stall, clk, rst_n, !in_pt.ready, &v_r)
  // a point behind a stalled output is never dropped
  `EXR_ASSERT_NXT(a_no_drop, clk, rst_n,
                  v_r[NST-2] && v_r[NST-1] && !out_pt.ready, v_r[NST-2])

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Testbench of the Euler XYZ point rotation core: directed and random point requests.
`default_nettype none
module tb_top;
  import exr_pkg::*;

  localparam int COORD_W     = COORD_BITS_DEF;
  localparam int FRAC_W      = COEF_FRAC_BITS_DEF;
  localparam int COEF_W      = FRAC_W + 2;
  localparam int NUM_COEF    = 6;
  // Pipe depth stated at the head of the core.
  localparam int LATENCY     = 7;
  // Cycles with no request moving on either channel before the run is declared hung.
  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_PER_PHASE = 568;

  // Register indexes past the last coefficient; the core must drop such writes.
  localparam logic [CFG_IDX_BITS-1:0] IDX_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] IDX_SPARE_B = 3'd7;

  // Q1.14 constants.
  localparam logic [COEF_W-1:0] Q_ONE     = 16'h4000;
  localparam logic [COEF_W-1:0] Q_NEG_ONE = 16'hC000;
  localparam logic [COEF_W-1:0] Q_HALF    = 16'h2000;
  localparam logic [COEF_W-1:0] Q_SQRT_HALF = 16'h2D41; // 11585, cos/sin of 45 deg
  localparam logic [COEF_W-1:0] Q_MIN     = 16'h8000;   // -2.0, most negative pattern
  localparam logic [COEF_W-1:0] Q_MAX     = 16'h7FFF;

  localparam longint OUT_MAX = (longint'(1) << COORD_W) - 1;
  localparam longint OUT_MIN = -(longint'(1) << COORD_W);

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      last;
  } point_t;

  typedef struct packed {
    logic signed [COORD_W:0] x;
    logic signed [COORD_W:0] y;
    logic signed [COORD_W:0] z;
    logic                    last;
  } rotated_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [COEF_W-1:0]        cfg_data;

  exr_in_if  #(.COORD_BITS(COORD_W)) in_ch ();
  exr_out_if #(.COORD_BITS(COORD_W)) out_ch ();

  euler_xyz_point_rotation_core #(
    .COORD_BITS     (COORD_W),
    .COEF_FRAC_BITS (FRAC_W)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pt     (in_ch),
    .out_pt    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow of the coefficient registers, indexed by cfg_reg_t.
  logic signed [COEF_W-1:0] coef [NUM_COEF];

  // Rotated points still owed by the core, oldest first.
  rotated_t rotated_q [$];
  rotated_t want;
  int       mismatches = 0;

  // Idle rates in percent; the receiver also honors a long hold-off count.
  int send_idle_pct = 8;
  int recv_stall_pct = 59;
  int hold_left = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Fixed-point sum to integer, ties go toward +infinity (floor of v + 0.5).
  function automatic longint half_up(longint v);
    return (v + (longint'(1) << (FRAC_W - 1))) >>> FRAC_W;
  endfunction

  function automatic logic signed [COORD_W:0] clamp_out(longint v);
    if (v > OUT_MAX) v = OUT_MAX;
    if (v < OUT_MIN) v = OUT_MIN;
    return v[COORD_W:0];
  endfunction

  // X, then Y, then Z, each stage rounded to integer before the next.
  function automatic rotated_t rotate_point(point_t p);
    longint   x, y, z, t;
    rotated_t r;
    x = longint'(p.x);
    y = longint'(p.y);
    z = longint'(p.z);
    t = half_up(y * coef[REG_COS_X] + z * coef[REG_SIN_X]);
    z = half_up(z * coef[REG_COS_X] - y * coef[REG_SIN_X]);
    y = t;
    t = half_up(x * coef[REG_COS_Y] + z * coef[REG_SIN_Y]);
    z = half_up(z * coef[REG_COS_Y] - x * coef[REG_SIN_Y]);
    x = t;
    t = half_up(x * coef[REG_COS_Z] - y * coef[REG_SIN_Z]);
    y = half_up(x * coef[REG_SIN_Z] + y * coef[REG_COS_Z]);
    x = t;
    r.x = clamp_out(x);
    r.y = clamp_out(y);
    r.z = clamp_out(z);
    r.last = p.last;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers (all entered and left at a falling edge)
  // ---------------------------------------------------------------------------

  // One register write; cfg_we stays high so back-to-back writes need one
  // assignment per edge. The caller drops cfg_we after the last write.
  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [COEF_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    unique case (idx)
      REG_COS_X, REG_SIN_X, REG_COS_Y, REG_SIN_Y, REG_COS_Z, REG_SIN_Z: coef[idx] = val;
      default: ; // spare index, core ignores it
    endcase
    @(negedge clk);
  endtask

  task automatic load_coefs(input logic [COEF_W-1:0] cx, sx, cy, sy, cz, sz);
    cfg_write(REG_COS_X, cx);
    cfg_write(REG_SIN_X, sx);
    cfg_write(REG_COS_Y, cy);
    cfg_write(REG_SIN_Y, sy);
    cfg_write(REG_COS_Z, cz);
    cfg_write(REG_SIN_Z, sz);
    cfg_we <= 1'b0;
  endtask

  // Offer one point request; valid stays up afterwards so a following request
  // goes out back to back. The prediction is queued at the accepting edge.
  task automatic send_point(input logic [COORD_W-1:0] x, y, z, input logic last);
    point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    p.last = last;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.x_in    <= p.x;
    in_ch.y_in    <= p.y;
    in_ch.z_in    <= p.z;
    in_ch.last_in <= p.last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    rotated_q.push_back(rotate_point(p));
    @(negedge clk);
  endtask

  // Stop offering and wait for every owed result; the pipe is then empty,
  // since each request yields exactly one result.
  task automatic drain;
    in_ch.valid <= 1'b0;
    while (rotated_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(15))
      0: return {1'b1, {(COORD_W-1){1'b0}}};
      1: return {1'b0, {(COORD_W-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return COORD_W'($urandom());
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values give the identity; coordinate extremes must pass untouched.
  task automatic test_reset_identity;
    send_point(16'h8000, 16'h7FFF, 16'h0000, 1'b0);
    send_point(16'h7FFF, 16'h8000, 16'hFFFF, 1'b1);
    send_point(16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_point(16'hFFFF, 16'h0001, 16'h8000, 1'b1);
  endtask

  // cos 0.5 on X turns odd coordinates into exact halves: ties round up.
  task automatic test_round_half_up;
    drain();
    load_coefs(Q_HALF, 16'h0000, Q_ONE, 16'h0000, Q_ONE, 16'h0000);
    send_point(16'd1, 16'd1, 16'd3, 1'b0);
    send_point(16'd1, -16'sd1, -16'sd3, 1'b1);
    send_point(16'd0, -16'sd32768, 16'd32767, 1'b0);
  endtask

  // Quarter turn about each axis alone, then half turns, then 45 deg on all.
  task automatic test_axis_turns;
    drain();
    load_coefs(16'h0000, Q_ONE, Q_ONE, 16'h0000, Q_ONE, 16'h0000);
    send_point(16'd1000, -16'sd2000, 16'd3000, 1'b0);
    drain();
    load_coefs(Q_ONE, 16'h0000, 16'h0000, Q_ONE, Q_ONE, 16'h0000);
    send_point(16'd1000, -16'sd2000, 16'd3000, 1'b1);
    drain();
    load_coefs(Q_ONE, 16'h0000, Q_ONE, 16'h0000, 16'h0000, Q_ONE);
    send_point(16'd1000, -16'sd2000, 16'd3000, 1'b0);
    drain();
    load_coefs(Q_NEG_ONE, 16'h0000, Q_NEG_ONE, 16'h0000, Q_NEG_ONE, 16'h0000);
    send_point(16'h8000, 16'h7FFF, 16'h8000, 1'b1);
    drain();
    load_coefs(Q_SQRT_HALF, Q_SQRT_HALF, Q_SQRT_HALF, Q_SQRT_HALF, Q_SQRT_HALF, Q_SQRT_HALF);
    send_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
    send_point(16'h8000, 16'h8000, 16'h8000, 1'b1);
  endtask

  // Coefficients past +-1.0 blow the range up; both clamp limits get hit.
  task automatic test_saturation;
    drain();
    load_coefs(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    send_point(16'h8000, 16'h8000, 16'h8000, 1'b0);
    send_point(16'h7FFF, 16'h8000, 16'h7FFF, 1'b1);
    drain();
    load_coefs(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    send_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
    send_point(16'h8000, 16'h7FFF, 16'h8000, 1'b1);
  endtask

  // Writes to spare indexes must leave every coefficient alone.
  task automatic test_spare_index;
    drain();
    load_coefs(16'h0000, Q_ONE, Q_ONE, 16'h0000, Q_NEG_ONE, 16'h0000);
    @(negedge clk);
    cfg_write(IDX_SPARE_A, Q_MIN);
    cfg_write(IDX_SPARE_B, Q_MAX);
    cfg_we <= 1'b0;
    send_point(16'd1234, 16'd5678, -16'sd910, 1'b0);
    send_point(16'h8000, 16'h7FFF, 16'h0001, 1'b1);
  endtask

  // Receiver holds off long enough for the pipe to fill and in_pt.ready to
  // drop while requests keep coming; then the sender waits out a full drain.
  task automatic test_backpressure;
    send_idle_pct = 0;
    hold_left = 60;
    repeat (30) send_point(rand_coord(), rand_coord(), rand_coord(), 1'($urandom_range(1)));
    drain();
    repeat (10) send_point(rand_coord(), rand_coord(), rand_coord(), 1'($urandom_range(1)));
  endtask

  // One idle setting, four coefficient sets: in-range, raw bit patterns,
  // extremes only, in-range again.
  task automatic random_phase(input int in_idle, input int out_stall);
    logic [COEF_W-1:0] v;
    send_idle_pct  = in_idle;
    recv_stall_pct = out_stall;
    for (int set_no = 0; set_no < 4; set_no++) begin
      drain();
      for (int r = 0; r < NUM_COEF; r++) begin
        case (set_no)
          1: v = COEF_W'($urandom());
          2: case ($urandom_range(4))
               0: v = Q_MIN;
               1: v = Q_NEG_ONE;
               2: v = '0;
               3: v = Q_ONE;
               default: v = Q_MAX;
             endcase
          default: v = COEF_W'($urandom_range(2 * 16384) - 16384);
        endcase
        cfg_write(r[CFG_IDX_BITS-1:0], v);
      end
      cfg_we <= 1'b0;
      for (int k = 0; k < RANDOM_PER_PHASE / 4; k++)
        send_point(rand_coord(), rand_coord(), rand_coord(), $urandom_range(7) == 0);
    end
  endtask

  task automatic test_random_traffic;
    random_phase(8, 59);
    random_phase(59, 8);
    random_phase(0, 0);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls plus an optional long hold-off, one update per edge.
  // ---------------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        out_ch.ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: every accepted result against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (rotated_q.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d last=%0b", $time,
                 out_ch.x_out, out_ch.y_out, out_ch.z_out, out_ch.last_out);
        mismatches++;
      end else begin
        want = rotated_q.pop_front();
        if (out_ch.x_out !== want.x) begin
          $display("%0t: x_out expected %0d got %0d", $time, want.x, out_ch.x_out);
          mismatches++;
        end
        if (out_ch.y_out !== want.y) begin
          $display("%0t: y_out expected %0d got %0d", $time, want.y, out_ch.y_out);
          mismatches++;
        end
        if (out_ch.z_out !== want.z) begin
          $display("%0t: z_out expected %0d got %0d", $time, want.z, out_ch.z_out);
          mismatches++;
        end
        if (out_ch.last_out !== want.last) begin
          $display("%0t: last_out expected %0b got %0b", $time, want.last, out_ch.last_out);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: ends the run if no request moves for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.x_in    = '0;
    in_ch.y_in    = '0;
    in_ch.z_in    = '0;
    in_ch.last_in = 1'b0;
    // Reset state of the registers: identity.
    coef[REG_COS_X] = Q_ONE;
    coef[REG_SIN_X] = '0;
    coef[REG_COS_Y] = Q_ONE;
    coef[REG_SIN_Y] = '0;
    coef[REG_COS_Z] = Q_ONE;
    coef[REG_SIN_Z] = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_identity();
    test_round_half_up();
    test_axis_turns();
    test_saturation();
    test_spare_index();
    test_backpressure();
    test_random_traffic();

    drain();
    // Catch any stray result after the last expected one.
    repeat (LATENCY * 3) @(posedge clk);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
`default_nettype wire
